FILE: src/nfecc_pkg.sv
// Types, codes and constants for the NOR flash ECC unit model.
package nfecc_pkg;

  localparam int UNITS_PER_SECTOR_C = 8;
  localparam int SECTORS_C          = 2;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CUT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_INDEX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_MODE   = 2'd2;

  typedef enum logic [1:0] {
    OP_ERASE   = 2'd0,
    OP_PROGRAM = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CUT_NOT_STARTED = 2'd0,
    CUT_PARTIAL     = 2'd1,
    CUT_COMPLETE    = 2'd2
  } cut_mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_ERASE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic        sector;
    logic [2:0]  unit;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } in_t;

  typedef struct packed {
    logic [63:0] read_low;
    logic [63:0] read_high;
    logic        ecc_bad;
    logic        cut_hit;
  } out_t;

  typedef struct packed {
    logic        torn;
    logic        ecc_off;
    logic        prog;
    logic [63:0] hi;
    logic [63:0] lo;
  } entry_t;

  localparam entry_t ERASED_ENTRY = '{torn: 1'b0, ecc_off: 1'b0, prog: 1'b0,
                                      hi: '1, lo: '1};

endpackage

FILE: src/nor_flash_ecc_unit_model_top.sv
// NOR flash ECC unit model: unit memory with read-modify-write sequencer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_t (op, sector, unit, data)
//   out      output     out_valid/out_stall  out_t (read data, ecc_bad, cut_hit)
//   cfg      input      cfg_valid/cfg_ready  index, data
//
// Read and program pass through accept, memory read and result load; an item
// that writes nothing (cut not started, bad address, op three) goes from accept
// straight to result load. Erase writes one unit per cycle, N units in all
// (N = UNITS_PER_SECTOR_P, or half of it on a torn erase). After reset a clearing
// pass writes all SECTORS_P * UNITS_PER_SECTOR_P units before the first item is taken.
// A stalled result holds in the output register; the next item runs up to its own result load.
module nor_flash_ecc_unit_model_top
  import nfecc_pkg::*;
#(
  parameter int UNITS_PER_SECTOR_P = UNITS_PER_SECTOR_C,
  parameter int SECTORS_P          = SECTORS_C
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NUNITS = UNITS_PER_SECTOR_P * SECTORS_P;
  localparam int AW     = (NUNITS > 1) ? $clog2(NUNITS) : 1;
  localparam int UW     = $clog2(UNITS_PER_SECTOR_P);
  localparam logic [UW-1:0] LAST_FULL = UW'(UNITS_PER_SECTOR_P - 1);
  localparam logic [UW-1:0] LAST_HALF = UW'(UNITS_PER_SECTOR_P / 2 - 1);

  entry_t mem [NUNITS];
  entry_t rdata_q;
  logic   mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t mem_wdata;

  state_e state_q, state_d;

  logic        cut_enable_q;
  logic [15:0] cut_index_q;
  logic [1:0]  cut_mode_q;
  logic [15:0] op_count_q;
  logic        cut_done_q;

  logic [1:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] base_q;
  logic [63:0]   dlo_q, dhi_q;
  logic          partial_q;
  logic [UW-1:0] cnt_q;
  logic [AW-1:0] clr_q;
  out_t          res_q;
  out_t          out_q;
  logic          out_valid_q;

  logic          in_acc, sec_ok, unit_ok, counted, fire, skip, partial;
  logic [AW-1:0] base, addr;
  logic          erase_last, out_load;
  entry_t        prog_entry;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign sec_ok  = 32'(in_i.sector) < SECTORS_P;
  assign unit_ok = 32'(in_i.unit) < UNITS_PER_SECTOR_P;
  assign counted = sec_ok && ((in_i.op == OP_ERASE) || ((in_i.op == OP_PROGRAM) && unit_ok));
  assign fire    = counted && cut_enable_q && !cut_done_q && (op_count_q == cut_index_q);
  assign skip    = fire && (cut_mode_q == CUT_NOT_STARTED);
  assign partial = fire && (cut_mode_q == CUT_PARTIAL);
  assign base    = in_i.sector ? AW'(UNITS_PER_SECTOR_P) : '0;
  assign addr    = base + AW'(in_i.unit);
  assign mem_raddr = addr;

  assign erase_last = cnt_q == (partial_q ? LAST_HALF : LAST_FULL);
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    prog_entry.lo      = rdata_q.lo & dlo_q;
    prog_entry.hi      = partial_q ? rdata_q.hi : (rdata_q.hi & dhi_q);
    prog_entry.prog    = 1'b1;
    prog_entry.torn    = rdata_q.torn | partial_q;
    prog_entry.ecc_off = rdata_q.ecc_off | rdata_q.prog;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(NUNITS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (sec_ok && (in_i.op == OP_ERASE) && !skip) begin
            state_d = ST_ERASE;
          end else if (sec_ok && unit_ok && (in_i.op == OP_READ)) begin
            state_d = ST_MODIFY;
          end else if (sec_ok && unit_ok && (in_i.op == OP_PROGRAM) && !skip) begin
            state_d = ST_MODIFY;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MODIFY: state_d = ST_FIN;
      ST_ERASE: begin
        if (erase_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = ERASED_ENTRY;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE: in_stall_o = 1'b0;
      ST_MODIFY: begin
        mem_we    = (op_q == OP_PROGRAM);
        mem_wdata = prog_entry;
      end
      ST_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = base_q + AW'(cnt_q);
        if (partial_q && (cnt_q == '0)) begin
          mem_wdata.torn = 1'b1;
          mem_wdata.prog = 1'b1;
        end
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      cnt_q        <= '0;
      cut_enable_q <= 1'b0;
      cut_index_q  <= '0;
      cut_mode_q   <= CUT_COMPLETE;
      op_count_q   <= '0;
      cut_done_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_ERASE) cnt_q <= erase_last ? '0 : cnt_q + UW'(1);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CUT_ENABLE: cut_enable_q <= cfg_data_i[0];
          CFG_CUT_INDEX:  cut_index_q  <= cfg_data_i;
          CFG_CUT_MODE:   cut_mode_q   <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_acc && counted) begin
        op_count_q <= op_count_q + 16'd1;
        if (fire) cut_done_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= in_i.op;
      addr_q    <= addr;
      base_q    <= base;
      dlo_q     <= in_i.data_low;
      dhi_q     <= in_i.data_high;
      partial_q <= partial;
      res_q     <= '{read_low: '0, read_high: '0, ecc_bad: 1'b0, cut_hit: fire};
    end
    if ((state_q == ST_MODIFY) && (op_q == OP_READ)) begin
      res_q.read_low  <= rdata_q.lo;
      res_q.read_high <= rdata_q.hi;
      res_q.ecc_bad   <= rdata_q.ecc_off | rdata_q.torn;
    end
    if (out_load) out_q <= res_q;
  end

endmodule

FILE: tb/sv/tb_nor_flash_ecc_unit_model_top.sv
// Testbench for the NOR flash ECC unit model: directed and random operations against a predictor.
module tb_nor_flash_ecc_unit_model_top;
  import nfecc_pkg::*;

  localparam logic [1:0] OP_NONE        = 2'd3;
  localparam logic [1:0] CUT_MODE_SPARE = 2'd3;
  localparam int         NUM_UNITS      = UNITS_PER_SECTOR_C * SECTORS_C;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  nor_flash_ecc_unit_model_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // flash image and cut state as the block should hold them
  logic [63:0] cell_lo [NUM_UNITS];
  logic [63:0] cell_hi [NUM_UNITS];
  bit          unit_prog [NUM_UNITS];
  bit          unit_ecc_off [NUM_UNITS];
  bit          unit_torn [NUM_UNITS];
  logic [15:0] op_count;
  bit          cut_fired;
  bit          arm_cut;
  logic [15:0] cut_at;
  logic [1:0]  cut_kind;

  in_t  flash_cmds [$];
  out_t expected_replies [$];
  int   mismatches = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_req = 1'b0;
  bit   quiet = 1'b0;

  function automatic void wipe_unit(int k);
    cell_lo[k]      = '1;
    cell_hi[k]      = '1;
    unit_prog[k]    = 1'b0;
    unit_ecc_off[k] = 1'b0;
    unit_torn[k]    = 1'b0;
  endfunction

  function automatic bit count_op();
    bit fire;
    fire = arm_cut && !cut_fired && (op_count == cut_at);
    op_count = op_count + 16'd1;
    if (fire) cut_fired = 1'b1;
    return fire;
  endfunction

  function automatic out_t flash_predict(in_t c);
    out_t r;
    int   base;
    int   k;
    bit   cut;
    r    = '0;
    base = c.sector * UNITS_PER_SECTOR_C;
    k    = base + int'(c.unit);
    case (c.op)
      OP_ERASE: begin
        cut = count_op();
        if (!cut || cut_kind != CUT_NOT_STARTED) begin
          if (cut && cut_kind == CUT_PARTIAL) begin
            for (int i = 0; i < UNITS_PER_SECTOR_C / 2; i++) wipe_unit(base + i);
            unit_torn[base] = 1'b1;
            unit_prog[base] = 1'b1;
          end else begin
            for (int i = 0; i < UNITS_PER_SECTOR_C; i++) wipe_unit(base + i);
          end
        end
        r.cut_hit = cut;
      end
      OP_PROGRAM: begin
        cut = count_op();
        if (!cut || cut_kind != CUT_NOT_STARTED) begin
          if (unit_prog[k]) unit_ecc_off[k] = 1'b1;
          cell_lo[k] = cell_lo[k] & c.data_low;
          if (cut && cut_kind == CUT_PARTIAL) unit_torn[k] = 1'b1;
          else cell_hi[k] = cell_hi[k] & c.data_high;
          unit_prog[k] = 1'b1;
        end
        r.cut_hit = cut;
      end
      OP_READ: begin
        r.read_low  = cell_lo[k];
        r.read_high = cell_hi[k];
        r.ecc_bad   = unit_ecc_off[k] | unit_torn[k];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic in_t mk_cmd(logic [1:0] op, logic sec, logic [2:0] un,
                                 logic [63:0] lo, logic [63:0] hi);
    in_t c;
    c.op        = op;
    c.sector    = sec;
    c.unit      = un;
    c.data_low  = lo;
    c.data_high = hi;
    return c;
  endfunction

  function automatic logic [63:0] rand_data();
    logic [63:0] d;
    int          b;
    d = '1;
    case ($urandom_range(0, 3))
      0: d = {$urandom, $urandom};
      1: begin
        b = $urandom_range(0, 7);
        d[8*b +: 8] = 8'($urandom_range(0, 255));
      end
      2: d[$urandom_range(0, 63)] = 1'b0;
      default: d = '1;
    endcase
    return d;
  endfunction

  function automatic in_t random_cmd();
    int          pick;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 12)      op = OP_ERASE;
    else if (pick < 55) op = OP_PROGRAM;
    else if (pick < 96) op = OP_READ;
    else                op = OP_NONE;
    return mk_cmd(op, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  rand_data(), rand_data());
  endfunction

  task automatic queue_random(int n);
    repeat (n) flash_cmds.push_back(random_cmd());
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    mismatches++;
  endtask

  // called at a rising edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CUT_ENABLE: arm_cut  = val[0];
      CFG_CUT_INDEX:  cut_at   = val;
      CFG_CUT_MODE:   cut_kind = val[1:0];
      default: begin
      end
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    do @(posedge clk_i);
    while (flash_cmds.size() != 0 || in_valid_i || expected_replies.size() != 0);
    repeat (16) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_replies.push_back(flash_predict(in_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (flash_cmds.size() != 0) begin
          in_i       <= flash_cmds.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        want = expected_replies.pop_front();
        if (out_o.read_low !== want.read_low)
          report_mismatch("read_low", out_o.read_low, want.read_low);
        if (out_o.read_high !== want.read_high)
          report_mismatch("read_high", out_o.read_high, want.read_high);
        if (out_o.ecc_bad !== want.ecc_bad)
          report_mismatch("ecc_bad", 64'(out_o.ecc_bad), 64'(want.ecc_bad));
        if (out_o.cut_hit !== want.cut_hit)
          report_mismatch("cut_hit", 64'(out_o.cut_hit), 64'(want.cut_hit));
      end
    end
  end

  initial begin
    logic [1:0]  mode;
    logic [15:0] cut_point;
    for (int k = 0; k < NUM_UNITS; k++) wipe_unit(k);
    op_count  = '0;
    cut_fired = 1'b0;
    arm_cut   = 1'b0;
    cut_at    = '0;
    cut_kind  = CUT_COMPLETE;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_CUT_ENABLE, 16'd0);
    write_reg(CFG_CUT_INDEX, 16'd0);
    write_reg(CFG_CUT_MODE, 16'(CUT_PARTIAL));

    flash_cmds.push_back(mk_cmd(OP_READ, 1'b0, 3'd0, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b1, 3'd7, '1, '1));
    flash_cmds.push_back(mk_cmd(OP_PROGRAM, 1'b0, 3'd0, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b0, 3'd0, '0, '0));
    // reprogram disables ECC
    flash_cmds.push_back(mk_cmd(OP_PROGRAM, 1'b0, 3'd0, '1, '1));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b0, 3'd0, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_PROGRAM, 1'b1, 3'd7, {16{4'hA}}, {16{4'h5}}));
    flash_cmds.push_back(mk_cmd(OP_PROGRAM, 1'b1, 3'd3, '1, '0));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b1, 3'd7, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_NONE, 1'b1, 3'd7, '1, '1));
    flash_cmds.push_back(mk_cmd(OP_ERASE, 1'b0, 3'd5, '1, '0));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b0, 3'd0, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_ERASE, 1'b1, 3'd0, '0, '1));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b1, 3'd7, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b1, 3'd3, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_PROGRAM, 1'b1, 3'd7, {16{4'h5}}, {16{4'hA}}));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b1, 3'd7, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_NONE, 1'b0, 3'd0, '0, '0));
    flash_cmds.push_back(mk_cmd(OP_READ, 1'b0, 3'd7, '0, '0));
    drain_results();

    // armed, but the count is already past zero
    write_reg(CFG_CUT_ENABLE, 16'd1);
    write_reg(CFG_CUT_MODE, 16'(CUT_NOT_STARTED));
    queue_random(200);
    hold_req = 1'b1;
    drain_results();

    // the one cut of the run, in a random variant
    mode      = 2'($urandom_range(0, 3));
    cut_point = op_count + 16'($urandom_range(3, 30));
    write_reg(CFG_CUT_INDEX, cut_point);
    write_reg(CFG_CUT_MODE, 16'(mode));
    queue_random(300);
    drain_results();

    write_reg(CFG_CUT_ENABLE, 16'd0);
    write_reg(CFG_CUT_INDEX, 16'hFFFF);
    write_reg(CFG_CUT_MODE, 16'(CUT_MODE_SPARE));
    queue_random(250);
    while (flash_cmds.size() != 0) @(posedge clk_i);
    quiet = 1'b1;
    queue_random(150);
    drain_results();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
src/nfecc_pkg.sv
src/nor_flash_ecc_unit_model_top.sv
tb/sv/tb_nor_flash_ecc_unit_model_top.sv
